### rtl/bced_pkg.sv
// Package: shared constants, codes and word types of the binary cross erode/dilate unit.
`timescale 1ns / 1ps

package bced_pkg;

   // frame size limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MAX_RADIUS = 7;

   // fixed field widths
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int RADIUS_W   = 3;
   localparam int PIXEL_W    = 8;
   localparam int CSR_DATA_W = 13;

   // derived widths
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2 * MAX_RADIUS + 1);
   localparam int HIST_W = 2 * MAX_RADIUS;
   localparam int WIN_W  = 2 * MAX_RADIUS + 1;
   localparam int VDLY_W = MAX_RADIUS + 1;
   localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                  + MAX_RADIUS + 1);
   localparam int LAG_W  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

   // register reset values
   localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH   = 11'd1024;
   localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT  = 13'd1024;
   localparam logic [RADIUS_W-1:0] RST_KERNEL_RADIUS = 3'd1;

   // operation and item codes
   localparam logic OP_ERODE   = 1'b0;
   localparam logic OP_DILATE  = 1'b1;
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_KERNEL_RADIUS = 2'd2,
      CSR_OPERATION     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]  width;
      logic [HEIGHT_W-1:0] height;
      logic [RADIUS_W-1:0] radius;
      logic                operation;
   } frame_cfg_type;

   typedef struct packed {
      logic               mode;
      logic [PIXEL_W-1:0] pixel_value;
   } req_word_type;

   typedef struct packed {
      logic mask_bit;
      logic frame_last;
   } rsp_word_type;

   // one effective item handed from the front end to the filter stage
   typedef struct packed {
      logic             pix;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             emit;
      logic             last;
   } stage_item_type;

endpackage

### rtl/bced_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bced_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port; read during write returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bced_ctrl.sv
// Front end: frame parameter latch, input position counters and item classification.
`timescale 1ns / 1ps

module bced_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  bced_pkg::frame_cfg_type  csr_cfg,
   input  logic                     req_valid,
   input  bced_pkg::req_word_type   req_word,
   output logic                     req_stall,
   input  logic                     s1_hold,
   output logic                     load,
   output bced_pkg::stage_item_type item,
   output bced_pkg::frame_cfg_type  frame_cfg
);

   import bced_pkg::*;

   localparam int AREA_W = WIDTH_W + HEIGHT_W;
   localparam int LPRD_W = RADIUS_W + WIDTH_W;

   frame_cfg_type    fresh, use_cfg, cur_ff, cur_in;
   logic [CNT_W-1:0] n_ff, n_in, total_m1_ff, total_m1_in;
   logic [LAG_W-1:0] lag_ff, lag_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [AREA_W-1:0] area;
   logic [LPRD_W-1:0] lag_full;
   logic accept, frame_start, past_end, pix_ok, drain_ok, effective;
   logic emit, last, col_wrap;

   // clamp the written registers into the supported range
   always_comb begin
      fresh = csr_cfg;
      if (csr_cfg.width == '0) begin
         fresh.width = WIDTH_W'(1);
      end else if (csr_cfg.width > WIDTH_W'(MAX_WIDTH)) begin
         fresh.width = WIDTH_W'(MAX_WIDTH);
      end
      if (csr_cfg.height == '0) begin
         fresh.height = HEIGHT_W'(1);
      end else if (csr_cfg.height > HEIGHT_W'(MAX_HEIGHT)) begin
         fresh.height = HEIGHT_W'(MAX_HEIGHT);
      end
      if (csr_cfg.radius > RADIUS_W'(MAX_RADIUS)) begin
         fresh.radius = RADIUS_W'(MAX_RADIUS);
      end
   end

   // frame size and lag for the latch
   assign area     = AREA_W'(fresh.width) * AREA_W'(fresh.height);
   assign lag_full = LPRD_W'(fresh.radius) * LPRD_W'(fresh.width) + LPRD_W'(fresh.radius);

   assign frame_start = (n_ff == '0);
   assign use_cfg     = frame_start ? fresh : cur_ff;
   assign req_stall   = s1_hold;
   assign accept      = req_valid && !req_stall;

   // classify the word: pixels only before the frame is full, drains only after
   assign past_end  = !frame_start && (n_ff > total_m1_ff);
   assign pix_ok    = (req_word.mode == MODE_PIXEL) && !past_end;
   assign drain_ok  = (req_word.mode == MODE_DRAIN) && past_end;
   assign effective = accept && (pix_ok || drain_ok);

   // at frame start the lag and end tests reduce to the fresh parameters
   always_comb begin
      if (frame_start) begin
         emit = (fresh.radius == '0);
         last = (fresh.radius == '0) && (fresh.width == WIDTH_W'(1))
                && (fresh.height == HEIGHT_W'(1));
      end else begin
         emit = (n_ff >= CNT_W'(lag_ff));
         last = ((n_ff - CNT_W'(lag_ff)) == total_m1_ff);
      end
   end

   assign col_wrap = ((WIDTH_W'(col_ff) + WIDTH_W'(1)) == use_cfg.width);

   // next state
   always_comb begin
      cur_in      = cur_ff;
      total_m1_in = total_m1_ff;
      lag_in      = lag_ff;
      n_in        = n_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (accept && frame_start) begin
         cur_in      = fresh;
         total_m1_in = CNT_W'(area - AREA_W'(1));
         lag_in      = LAG_W'(lag_full);
      end
      if (effective) begin
         if (last) begin
            n_in   = '0;
            col_in = '0;
            row_in = '0;
         end else begin
            n_in = n_ff + CNT_W'(1);
            if (col_wrap) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= '{width: RST_FRAME_WIDTH, height: RST_FRAME_HEIGHT,
                          radius: RST_KERNEL_RADIUS, operation: OP_ERODE};
         total_m1_ff <= '0;
         lag_ff      <= '0;
         n_ff        <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         cur_ff      <= cur_in;
         total_m1_ff <= total_m1_in;
         lag_ff      <= lag_in;
         n_ff        <= n_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
      end
   end

   // hand the item to the filter stage
   assign load      = effective;
   assign item.pix  = (req_word.mode == MODE_PIXEL) && (|req_word.pixel_value);
   assign item.col  = col_ff;
   assign item.row  = row_ff;
   assign item.emit = emit;
   assign item.last = last;
   assign frame_cfg = cur_ff;

endmodule

### rtl/bced_filter.sv
// Filter stage: column window from the line store, vertical and horizontal arms, result register.
`timescale 1ns / 1ps

module bced_filter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  bced_pkg::stage_item_type       item,
   input  bced_pkg::frame_cfg_type        frame_cfg,
   input  logic [bced_pkg::HIST_W-1:0]    ram_rd_data,
   output logic                           ram_wr_en,
   output logic [bced_pkg::COL_W-1:0]     ram_wr_addr,
   output logic [bced_pkg::HIST_W-1:0]    ram_wr_data,
   output logic                           s1_hold,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bced_pkg::rsp_word_type         rsp_word
);

   import bced_pkg::*;

   localparam int VC_W       = ((ROW_W > HEIGHT_W) ? ROW_W : HEIGHT_W) + 1;
   localparam int HC_W       = WIDTH_W + 1;
   localparam int WIN_IDX_W  = $clog2(WIN_W);
   localparam int VDLY_IDX_W = $clog2(VDLY_W);

   stage_item_type    s1_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic              go, out_free, dilate;
   logic              byp_valid_ff;
   logic [HIST_W-1:0] byp_data_ff, hist;
   logic [WIN_W-1:0]  win, vincl, hincl, hsr_ff, hsr_in;
   logic [VDLY_W-1:0] vsr_ff, vsr_in;
   logic [COL_W-1:0]  ocol_ff, ocol_in;
   logic [RADIUS_W:0] r2;
   logic [HC_W-1:0]   ocol_r;
   logic [WIN_IDX_W-1:0]  c_idx;
   logic [VDLY_IDX_W-1:0] v_idx;
   logic              v_bit, c_bit, vc_bit, h_bit;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   // stage advance: a result needs room in the output register
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign go       = s1_valid_ff && (!s1_ff.emit || out_free);
   assign s1_hold  = s1_valid_ff && !go;
   assign s1_valid_in = load ? 1'b1 : (go ? 1'b0 : s1_valid_ff);

   // column history, forwarded when the previous word wrote the same column
   assign hist = byp_valid_ff ? byp_data_ff : ram_rd_data;
   assign win  = {hist, s1_ff.pix};

   assign ram_wr_en   = go;
   assign ram_wr_addr = s1_ff.col;
   assign ram_wr_data = {hist[HIST_W-2:0], s1_ff.pix};

   assign dilate = (frame_cfg.operation == OP_DILATE);
   assign r2     = {frame_cfg.radius, 1'b0};
   assign ocol_r = HC_W'(ocol_ff) + HC_W'(frame_cfg.radius);

   // arm masks: within the kernel and inside the frame
   always_comb begin
      for (int j = 0; j < WIN_W; j++) begin
         vincl[j] = (VC_W'(j) <= VC_W'(r2)) && (VC_W'(j) <= VC_W'(s1_ff.row))
                    && (VC_W'(s1_ff.row) < (VC_W'(frame_cfg.height) + VC_W'(j)));
         hincl[j] = (HC_W'(j) <= HC_W'(r2)) && (HC_W'(j) <= ocol_r)
                    && (ocol_r < (HC_W'(frame_cfg.width) + HC_W'(j)));
      end
   end

   // vertical arm centered radius rows above the newest row
   assign v_bit = dilate ? (|(win & vincl)) : (&(win | ~vincl));
   assign c_idx = WIN_IDX_W'(frame_cfg.radius);
   assign c_bit = win[c_idx];

   // center row line and vertical result delay
   assign hsr_in = {hsr_ff[WIN_W-2:0], c_bit};
   assign vsr_in = {vsr_ff[VDLY_W-2:0], v_bit};
   assign v_idx  = VDLY_IDX_W'(frame_cfg.radius);
   assign vc_bit = vsr_in[v_idx];
   assign h_bit  = dilate ? (|(hsr_in & hincl)) : (&(hsr_in | ~hincl));

   // output column counter
   always_comb begin
      ocol_in = ocol_ff;
      if (go && s1_ff.emit) begin
         if (s1_ff.last || ((WIDTH_W'(ocol_ff) + WIDTH_W'(1)) == frame_cfg.width)) begin
            ocol_in = '0;
         end else begin
            ocol_in = ocol_ff + COL_W'(1);
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (go && s1_ff.emit) begin
         rsp_valid_in         = 1'b1;
         rsp_word_in.mask_bit = dilate ? (vc_bit | h_bit) : (vc_bit & h_bit);
         rsp_word_in.frame_last = s1_ff.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         ocol_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         ocol_ff      <= ocol_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            byp_valid_ff <= go && (s1_ff.col == item.col);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff       <= item;
         byp_data_ff <= ram_wr_data;
      end
      if (go) begin
         hsr_ff <= hsr_in;
         vsr_ff <= vsr_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef SYNTH
   a_no_load_on_hold: assert property (@(posedge clock) disable iff (reset)
      s1_hold |-> !load)
      else $error("word loaded while filter stage holds");

   a_last_clears_col: assert property (@(posedge clock) disable iff (reset)
      (go && s1_ff.emit && s1_ff.last) |=> (ocol_ff == '0))
      else $error("output column not cleared after frame end");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      (WIDTH_W'(ocol_ff) < frame_cfg.width))
      else $error("output column beyond frame width");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      (go && s1_ff.emit) |=> (rsp_valid_ff && (rsp_word_ff.frame_last == $past(s1_ff.last))))
      else $error("filter result not presented");
`endif

endmodule

### rtl/binary_cross_erode_dilate_unit.sv
// Top level of the binary cross erode/dilate unit: registers, line store and pipeline.
// Input words (req_) carry a mode bit and an 8-bit mask pixel, nonzero meaning set;
// mode 1 is a drain word that pushes out remaining results after the last pixel.
// Result words (rsp_) carry the filtered mask bit and frame_last on a frame's final bit.
// Results follow raster order, radius*width+radius accepted words behind the input;
// each word is registered in the filter stage, then its result in the result register.
// Throughput is one word per cycle unless stalled, set by the read-modify-write of the
// column store (one read and one write per cycle, with forwarding when a column is hit
// again). The user must write registers through csr_ only while the unit is idle; the
// unit itself does not enforce this. Registers are sampled at the first word of each
// frame. Pixels after a full frame and drains before it are dropped. Reset clears all
// control state; the line store needs no clearing, as history rows from outside the
// current frame are masked off. Under rsp_stall, words enter the filter stage until
// one with a result waits there, then req_stall rises until the result register frees.
`timescale 1ns / 1ps

module binary_cross_erode_dilate_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bced_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bced_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_wr_en,
   input  bced_pkg::csr_index_type             csr_index,
   input  logic [bced_pkg::CSR_DATA_W-1:0]     csr_data
);

   import bced_pkg::*;

   frame_cfg_type    csr_ff, csr_in, frame_cfg;
   stage_item_type   item;
   logic             load, s1_hold;
   logic             ram_wr_en;
   logic [COL_W-1:0] ram_wr_addr;
   logic [HIST_W-1:0] ram_wr_data, ram_rd_data;

   // register write decode
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:   csr_in.width     = csr_data[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT:  csr_in.height    = csr_data[HEIGHT_W-1:0];
            CSR_KERNEL_RADIUS: csr_in.radius    = csr_data[RADIUS_W-1:0];
            CSR_OPERATION:     csr_in.operation = csr_data[0];
            default:           csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{width: RST_FRAME_WIDTH, height: RST_FRAME_HEIGHT,
                     radius: RST_KERNEL_RADIUS, operation: OP_ERODE};
      end else begin
         csr_ff <= csr_in;
      end
   end

   bced_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_cfg   (csr_ff),
      .req_valid (req_valid),
      .req_word  (req_word),
      .req_stall (req_stall),
      .s1_hold   (s1_hold),
      .load      (load),
      .item      (item),
      .frame_cfg (frame_cfg)
   );

   // column store: past rows of each column, newest in the low bit
   bced_ram #(
      .WIDTH (HIST_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (load),
      .rd_addr (item.col),
      .rd_data (ram_rd_data)
   );

   bced_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .item        (item),
      .frame_cfg   (frame_cfg),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .s1_hold     (s1_hold),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule
